>>> rtl/nmea_gga_field_extractor_macros.svh
// assertion macros for the gga sentence field extractor
// no dependencies; included by the top level
`ifndef NMEA_GGA_FIELD_EXTRACTOR_MACROS_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_MACROS_SVH

// condition that must hold at every rising clock edge outside reset
`define NGFE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// consequent that must hold in the same cycle as the antecedent
`define NGFE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/ngfe_pkg.sv
// types, character codes and constant helpers for the gga sentence field extractor
// no dependencies; imported by nmea_gga_field_extractor
package ngfe_pkg;

   typedef enum logic [1:0] {
      STATUS_FIX        = 2'd0,
      STATUS_NO_CONN    = 2'd1,
      STATUS_NOT_GGA    = 2'd2,
      STATUS_INCOMPLETE = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [6:0]  sat_count;
      logic        time_valid;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
   } head_type;

   localparam int FIELD_W   = 4;
   localparam int CIF_W     = 3;
   localparam int FCNT_W    = 3;
   localparam int IP_W      = 17;
   localparam int IPW_W     = 20;
   localparam int DEG_W     = 10;
   localparam int MIN_W     = 7;
   localparam int DEGM_W    = 30;
   localparam int COORD_W   = 31;
   localparam int TAG_LEN   = 6;
   localparam int TIME_CHARS = 6;
   localparam int MIN_FIELDS = 10;

   localparam logic [FIELD_W-1:0] FIELD_TIME     = 4'd1;
   localparam logic [FIELD_W-1:0] FIELD_LAT      = 4'd2;
   localparam logic [FIELD_W-1:0] FIELD_LAT_HEMI = 4'd3;
   localparam logic [FIELD_W-1:0] FIELD_LON      = 4'd4;
   localparam logic [FIELD_W-1:0] FIELD_LON_HEMI = 4'd5;
   localparam logic [FIELD_W-1:0] FIELD_FIX      = 4'd6;
   localparam logic [FIELD_W-1:0] FIELD_SATS     = 4'd7;

   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_COMMA    = 8'h2c;
   localparam logic [7:0] CHAR_DOT      = 8'h2e;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_SOUTH    = 8'h53;
   localparam logic [7:0] CHAR_WEST     = 8'h57;
   localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHAR_G        = 8'h47;
   localparam logic [7:0] CHAR_P        = 8'h50;
   localparam logic [7:0] CHAR_A        = 8'h41;

   localparam logic [CIF_W-1:0]  CIF_MAX  = 3'd7;
   localparam logic [IP_W-1:0]   INT_SAT  = 17'd99999;
   localparam logic [6:0]        SAT_MAX  = 7'd99;
   localparam logic [6:0]        HOURS_PER_DAY = 7'd24;
   localparam logic [DEGM_W-1:0] MICRO    = 30'd1000000;
   localparam logic [12:0]       DEG_RECIP = 13'd5242;
   localparam int                DEG_RECIP_SH = 17;
   localparam logic [7:0]        CENT     = 8'd100;

   // expected prefix character at each of the first six positions
   function automatic logic [7:0] tag_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = CHAR_DOLLAR;
         3'd1:    c = CHAR_G;
         3'd2:    c = CHAR_P;
         3'd3:    c = CHAR_G;
         3'd4:    c = CHAR_G;
         3'd5:    c = CHAR_A;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // elaboration-time powers of ten
   function automatic longint unsigned pow10(input int n);
      longint unsigned r;
      r = 1;
      for (int i = 0; i < n; i++) begin
         r = r * 10;
      end
      return r;
   endfunction

   // weight of fraction digit k when fractions are held scaled by 10^scale_dig
   function automatic longint unsigned frac_weight(input int scale_dig, input int frac_digits,
                                                   input int k);
      longint unsigned w;
      w = (k < frac_digits) ? pow10(scale_dig - 1 - k) : 0;
      return w;
   endfunction

   function automatic logic [6:0] digit_pair(input logic [3:0] hi, input logic [3:0] lo);
      logic [6:0] v;
      v = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
      return v;
   endfunction

   // (hh + 1) mod 24 for hh up to 99
   function automatic logic [6:0] hour_shift(input logic [6:0] hh);
      logic [6:0] v;
      v = hh + 7'd1;
      for (int i = 0; i < 4; i++) begin
         if (v >= HOURS_PER_DAY) begin
            v = v - HOURS_PER_DAY;
         end
      end
      return v;
   endfunction

endpackage

>>> rtl/nmea_gga_field_extractor.sv
// gga sentence field extractor: byte parser, sentence snapshot and coordinate pipeline
// depends on ngfe_pkg and nmea_gga_field_extractor_macros.svh
//
// usage
//   req channel: one sentence byte per transfer on req_ch; a zero byte ends the
//   sentence and yields exactly one transfer on the rsp channel, other bytes none.
//   csr port: csr_wr_en with csr_wr_data writes add_hour; write only while idle.
// throughput
//   one byte per cycle, terminators included, while req_stall is low; every byte is
//   applied to the field parse state as it is taken from the input register.
// pipeline
//   from the input register to rsp_valid, snapshot, degree split, scaling, reciprocal
//   multiply and remainder correction each take one stage.
// reset
//   synchronous, active high; clears the parse state, all stage valids and
//   add_hour; the block takes bytes in the first cycle after reset.
// stall
//   rsp_stall holds the output stage; earlier stages keep filling until the
//   pipeline is full, then a terminator waiting in the input register raises
//   req_stall. ordinary bytes keep flowing while no terminator is blocked.
`include "nmea_gga_field_extractor_macros.svh"

module nmea_gga_field_extractor #(
   parameter int MAX_BYTES   = 127,
   parameter int MAX_FIELDS  = 15,
   parameter int FRAC_DIGITS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_ch,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [6:0]          rsp_sat_count,
   output logic signed [30:0]  rsp_latitude_micro,
   output logic signed [30:0]  rsp_longitude_micro,
   output logic                rsp_time_valid,
   output logic [6:0]          rsp_hour,
   output logic [6:0]          rsp_minute,
   output logic [6:0]          rsp_second,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);
   import ngfe_pkg::*;

   localparam int BPOS_W    = $clog2(MAX_BYTES + 1);
   localparam int SCALE_DIG = (FRAC_DIGITS > 5) ? FRAC_DIGITS : 5;
   localparam longint unsigned SCALE = pow10(SCALE_DIG);
   localparam int FRAC_W    = $clog2(SCALE);
   localparam longint unsigned DIV_C = 6 * SCALE / 100000;
   localparam int DIV_W     = $clog2(DIV_C + 1);
   localparam int Y_W       = $clog2(100 * SCALE);
   localparam longint unsigned RECIP = (64'd1 << Y_W) / DIV_C;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = Y_W + RECIP_W + 1;
   localparam int QF_W      = $clog2(100 * SCALE / DIV_C + 1);

   localparam logic [FRAC_W-1:0] FRAC_WEIGHT [0:7] = '{
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 0)),
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 1)),
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 2)),
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 3)),
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 4)),
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 5)),
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 6)),
      FRAC_W'(frac_weight(SCALE_DIG, FRAC_DIGITS, 7))
   };

   // configuration
   logic add_hour_ff;

   // input register
   logic       byte_vld_ff;
   logic [7:0] byte_ff;
   logic       byte_take;
   logic       is_term;
   logic       term_go;

   // stage handshake
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // parse state
   logic [BPOS_W-1:0]  bpos_ff, bpos_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic [CIF_W-1:0]   cif_ff, cif_in;
   logic               prefix_ok_ff, prefix_ok_in;
   logic [3:0]         time_dig_ff [0:5];
   logic [3:0]         time_dig_in [0:5];
   logic               time_ok_ff, time_ok_in;
   logic [2:0]         tlen_ff, tlen_in;
   logic               fix_ff, fix_in;
   logic [6:0]         sat_ff, sat_in;
   logic               sat_stop_ff, sat_stop_in;
   logic [IP_W-1:0]    ip_ff [0:1];
   logic [IP_W-1:0]    ip_in [0:1];
   logic [FRAC_W-1:0]  fr_ff [0:1];
   logic [FRAC_W-1:0]  fr_in [0:1];
   logic [FCNT_W-1:0]  fcnt_ff [0:1];
   logic [FCNT_W-1:0]  fcnt_in [0:1];
   logic               in_frac_ff [0:1];
   logic               in_frac_in [0:1];
   logic               stop_ff [0:1];
   logic               stop_in [0:1];
   logic               neg_ff [0:1];
   logic               neg_in [0:1];

   // pipeline stages
   logic               s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   head_type           s1_head_ff, s2_head_ff, s3_head_ff, s4_head_ff, s5_head_ff;
   head_type           s1_head_in;
   logic [IP_W-1:0]    s1_ip_ff [0:1];
   logic [IP_W-1:0]    s1_ip_in [0:1];
   logic [DEG_W-1:0]   s1_qd_ff [0:1];
   logic [DEG_W-1:0]   s1_qd_in [0:1];
   logic [FRAC_W-1:0]  s1_fr_ff [0:1];
   logic [FRAC_W-1:0]  s1_fr_in [0:1];
   logic               s1_neg_ff [0:1];
   logic               s1_neg_in [0:1];
   logic [DEG_W-1:0]   s2_deg_ff [0:1];
   logic [DEG_W-1:0]   s2_deg_in [0:1];
   logic [MIN_W-1:0]   s2_min_ff [0:1];
   logic [MIN_W-1:0]   s2_min_in [0:1];
   logic [FRAC_W-1:0]  s2_fr_ff [0:1];
   logic               s2_neg_ff [0:1];
   logic [Y_W-1:0]     s3_y_ff [0:1];
   logic [Y_W-1:0]     s3_y_in [0:1];
   logic [DEGM_W-1:0]  s3_degm_ff [0:1];
   logic [DEGM_W-1:0]  s3_degm_in [0:1];
   logic               s3_neg_ff [0:1];
   logic [QF_W-1:0]    s4_q_ff [0:1];
   logic [QF_W-1:0]    s4_q_in [0:1];
   logic [Y_W-1:0]     s4_y_ff [0:1];
   logic [DEGM_W-1:0]  s4_degm_ff [0:1];
   logic               s4_neg_ff [0:1];
   logic signed [COORD_W-1:0] s5_coord_ff [0:1];
   logic signed [COORD_W-1:0] s5_coord_in [0:1];

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         add_hour_ff <= 1'b0;
      end else if (csr_wr_en) begin
         add_hour_ff <= csr_wr_data;
      end
   end

   // handshake chain
   assign rdy5 = !s5_vld_ff || !rsp_stall;
   assign rdy4 = !s4_vld_ff || rdy5;
   assign rdy3 = !s3_vld_ff || rdy4;
   assign rdy2 = !s2_vld_ff || rdy3;
   assign rdy1 = !s1_vld_ff || rdy2;

   assign is_term   = (byte_ff == CHAR_NUL);
   assign byte_take = byte_vld_ff && (!is_term || rdy1);
   assign term_go   = byte_vld_ff && is_term && rdy1;
   assign req_stall = byte_vld_ff && !byte_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         byte_vld_ff <= 1'b1;
      end else if (byte_take) begin
         byte_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_ch;
      end
   end

   // per byte field update
   always_comb begin
      logic              is_digit;
      logic [3:0]        digit;
      logic [IPW_W-1:0]  ip_wide;
      logic [9:0]        sat_wide;
      logic [FIELD_W-1:0] cfield;

      is_digit = byte_ff inside {[CHAR_ZERO:CHAR_NINE]};
      digit    = byte_ff[3:0];
      ip_wide  = '0;
      sat_wide = '0;
      cfield   = FIELD_LAT;

      bpos_in      = bpos_ff;
      field_in     = field_ff;
      cif_in       = cif_ff;
      prefix_ok_in = prefix_ok_ff;
      time_dig_in  = time_dig_ff;
      time_ok_in   = time_ok_ff;
      tlen_in      = tlen_ff;
      fix_in       = fix_ff;
      sat_in       = sat_ff;
      sat_stop_in  = sat_stop_ff;
      ip_in        = ip_ff;
      fr_in        = fr_ff;
      fcnt_in      = fcnt_ff;
      in_frac_in   = in_frac_ff;
      stop_in      = stop_ff;
      neg_in       = neg_ff;

      if (byte_take) begin
         if (is_term) begin
            bpos_in      = '0;
            field_in     = '0;
            cif_in       = '0;
            prefix_ok_in = 1'b1;
            time_ok_in   = 1'b1;
            tlen_in      = '0;
            fix_in       = 1'b0;
            sat_in       = '0;
            sat_stop_in  = 1'b0;
            for (int t = 0; t < TIME_CHARS; t++) begin
               time_dig_in[t] = '0;
            end
            for (int k = 0; k < 2; k++) begin
               ip_in[k]      = '0;
               fr_in[k]      = '0;
               fcnt_in[k]    = '0;
               in_frac_in[k] = 1'b0;
               stop_in[k]    = 1'b0;
               neg_in[k]     = 1'b0;
            end
         end else if (bpos_ff < BPOS_W'(MAX_BYTES)) begin
            if (bpos_ff < BPOS_W'(TAG_LEN) && byte_ff != tag_char(bpos_ff[2:0])) begin
               prefix_ok_in = 1'b0;
            end
            bpos_in = bpos_ff + BPOS_W'(1);
            if (byte_ff == CHAR_COMMA) begin
               if (field_ff < FIELD_W'(MAX_FIELDS - 1)) begin
                  field_in = field_ff + FIELD_W'(1);
                  cif_in   = '0;
               end
            end else begin
               case (field_ff)
                  FIELD_TIME: begin
                     if (cif_ff < CIF_W'(TIME_CHARS)) begin
                        if (is_digit) begin
                           time_dig_in[cif_ff] = digit;
                           tlen_in = tlen_ff + 3'd1;
                        end else begin
                           time_ok_in = 1'b0;
                        end
                     end
                  end
                  FIELD_LAT_HEMI: begin
                     if (cif_ff == '0) begin
                        neg_in[0] = (byte_ff == CHAR_SOUTH);
                     end
                  end
                  FIELD_LON_HEMI: begin
                     if (cif_ff == '0) begin
                        neg_in[1] = (byte_ff == CHAR_WEST);
                     end
                  end
                  FIELD_FIX: begin
                     if (cif_ff == '0) begin
                        fix_in = (byte_ff != CHAR_ZERO);
                     end
                  end
                  FIELD_SATS: begin
                     if (!sat_stop_ff) begin
                        if (is_digit) begin
                           sat_wide = 10'(sat_ff) * 10'd10 + 10'(digit);
                           sat_in   = (sat_wide > 10'(SAT_MAX)) ? SAT_MAX : sat_wide[6:0];
                        end else begin
                           sat_stop_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               for (int k = 0; k < 2; k++) begin
                  cfield = (k == 0) ? FIELD_LAT : FIELD_LON;
                  if (field_ff == cfield && !stop_ff[k]) begin
                     if (is_digit) begin
                        if (in_frac_ff[k]) begin
                           if (fcnt_ff[k] < FCNT_W'(FRAC_DIGITS)) begin
                              fr_in[k]   = fr_ff[k] + FRAC_W'(digit) * FRAC_WEIGHT[fcnt_ff[k]];
                              fcnt_in[k] = fcnt_ff[k] + FCNT_W'(1);
                           end
                        end else begin
                           ip_wide  = IPW_W'(ip_ff[k]) * IPW_W'(10) + IPW_W'(digit);
                           ip_in[k] = (ip_wide > IPW_W'(INT_SAT)) ? INT_SAT
                                                                   : ip_wide[IP_W-1:0];
                        end
                     end else if (byte_ff == CHAR_DOT && !in_frac_ff[k]) begin
                        in_frac_in[k] = 1'b1;
                     end else begin
                        stop_in[k] = 1'b1;
                     end
                  end
               end
               if (cif_ff != CIF_MAX) begin
                  cif_in = cif_ff + CIF_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpos_ff      <= '0;
         field_ff     <= '0;
         cif_ff       <= '0;
         prefix_ok_ff <= 1'b1;
         time_ok_ff   <= 1'b1;
         tlen_ff      <= '0;
         fix_ff       <= 1'b0;
         sat_ff       <= '0;
         sat_stop_ff  <= 1'b0;
         for (int t = 0; t < TIME_CHARS; t++) begin
            time_dig_ff[t] <= '0;
         end
         for (int k = 0; k < 2; k++) begin
            ip_ff[k]      <= '0;
            fr_ff[k]      <= '0;
            fcnt_ff[k]    <= '0;
            in_frac_ff[k] <= 1'b0;
            stop_ff[k]    <= 1'b0;
            neg_ff[k]     <= 1'b0;
         end
      end else begin
         bpos_ff      <= bpos_in;
         field_ff     <= field_in;
         cif_ff       <= cif_in;
         prefix_ok_ff <= prefix_ok_in;
         time_dig_ff  <= time_dig_in;
         time_ok_ff   <= time_ok_in;
         tlen_ff      <= tlen_in;
         fix_ff       <= fix_in;
         sat_ff       <= sat_in;
         sat_stop_ff  <= sat_stop_in;
         ip_ff        <= ip_in;
         fr_ff        <= fr_in;
         fcnt_ff      <= fcnt_in;
         in_frac_ff   <= in_frac_in;
         stop_ff      <= stop_in;
         neg_ff       <= neg_in;
      end
   end

   // sentence snapshot and degree estimate
   always_comb begin
      status_type  st;
      logic        fix_rep;
      logic [6:0]  hh;
      logic [27:0] qprod;

      qprod = '0;
      if (bpos_ff == '0) begin
         st = STATUS_NO_CONN;
      end else if (!prefix_ok_ff || bpos_ff < BPOS_W'(TAG_LEN)) begin
         st = STATUS_NOT_GGA;
      end else if ((5'(field_ff) + 5'd1) < 5'(MIN_FIELDS)) begin
         st = STATUS_INCOMPLETE;
      end else if (!fix_ff || sat_ff == '0) begin
         st = STATUS_NO_CONN;
      end else begin
         st = STATUS_FIX;
      end
      fix_rep = (st == STATUS_FIX);

      hh = digit_pair(time_dig_ff[0], time_dig_ff[1]);
      if (add_hour_ff) begin
         hh = hour_shift(hh);
      end

      s1_head_in.status     = st;
      s1_head_in.sat_count  = fix_rep ? sat_ff : '0;
      s1_head_in.time_valid = fix_rep && time_ok_ff && (tlen_ff == 3'(TIME_CHARS));
      s1_head_in.hour       = s1_head_in.time_valid ? hh : '0;
      s1_head_in.minute     = s1_head_in.time_valid
                              ? digit_pair(time_dig_ff[2], time_dig_ff[3]) : '0;
      s1_head_in.second     = s1_head_in.time_valid
                              ? digit_pair(time_dig_ff[4], time_dig_ff[5]) : '0;

      for (int k = 0; k < 2; k++) begin
         s1_ip_in[k]  = fix_rep ? ip_ff[k] : '0;
         s1_fr_in[k]  = fix_rep ? fr_ff[k] : '0;
         s1_neg_in[k] = fix_rep && neg_ff[k];
         qprod        = 28'(s1_ip_in[k][IP_W-1:2]) * 28'(DEG_RECIP);
         s1_qd_in[k]  = qprod[DEG_RECIP_SH +: DEG_W];
      end
   end

   // degree and minute split with one correction step
   always_comb begin
      logic [IP_W-1:0] rem;
      rem = '0;
      for (int k = 0; k < 2; k++) begin
         rem = s1_ip_ff[k] - IP_W'(s1_qd_ff[k]) * IP_W'(CENT);
         if (rem[7:0] >= CENT) begin
            s2_deg_in[k] = s1_qd_ff[k] + DEG_W'(1);
            s2_min_in[k] = MIN_W'(rem[7:0] - CENT);
         end else begin
            s2_deg_in[k] = s1_qd_ff[k];
            s2_min_in[k] = rem[MIN_W-1:0];
         end
      end
   end

   // minutes scaled together with the fraction, degrees in microdegrees
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         s3_y_in[k]    = Y_W'(s2_min_ff[k]) * Y_W'(SCALE) + Y_W'(s2_fr_ff[k]);
         s3_degm_in[k] = DEGM_W'(s2_deg_ff[k]) * MICRO;
      end
   end

   // reciprocal multiply for the minute to degree conversion
   always_comb begin
      logic [PROD_W-1:0] rprod;
      rprod = '0;
      for (int k = 0; k < 2; k++) begin
         rprod      = PROD_W'(s3_y_ff[k]) * PROD_W'(RECIP);
         s4_q_in[k] = rprod[Y_W +: QF_W];
      end
   end

   // remainder correction, sum and hemisphere sign
   always_comb begin
      logic [Y_W-1:0]     rem;
      logic [QF_W-1:0]    qf;
      logic [COORD_W-1:0] mag;
      rem = '0;
      qf  = '0;
      mag = '0;
      for (int k = 0; k < 2; k++) begin
         rem = s4_y_ff[k] - Y_W'(s4_q_ff[k]) * Y_W'(DIV_C);
         qf  = (rem >= Y_W'(DIV_C)) ? s4_q_ff[k] + QF_W'(1) : s4_q_ff[k];
         mag = COORD_W'(s4_degm_ff[k]) + COORD_W'(qf);
         s5_coord_in[k] = s4_neg_ff[k] ? -$signed(mag) : $signed(mag);
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_vld_ff <= term_go;
         end
         if (rdy2) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (rdy3) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (rdy4) begin
            s4_vld_ff <= s3_vld_ff;
         end
         if (rdy5) begin
            s5_vld_ff <= s4_vld_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_head_ff <= s1_head_in;
         s1_ip_ff   <= s1_ip_in;
         s1_qd_ff   <= s1_qd_in;
         s1_fr_ff   <= s1_fr_in;
         s1_neg_ff  <= s1_neg_in;
      end
      if (rdy2) begin
         s2_head_ff <= s1_head_ff;
         s2_deg_ff  <= s2_deg_in;
         s2_min_ff  <= s2_min_in;
         s2_fr_ff   <= s1_fr_ff;
         s2_neg_ff  <= s1_neg_ff;
      end
      if (rdy3) begin
         s3_head_ff <= s2_head_ff;
         s3_y_ff    <= s3_y_in;
         s3_degm_ff <= s3_degm_in;
         s3_neg_ff  <= s2_neg_ff;
      end
      if (rdy4) begin
         s4_head_ff <= s3_head_ff;
         s4_q_ff    <= s4_q_in;
         s4_y_ff    <= s3_y_ff;
         s4_degm_ff <= s3_degm_ff;
         s4_neg_ff  <= s3_neg_ff;
      end
      if (rdy5) begin
         s5_head_ff  <= s4_head_ff;
         s5_coord_ff <= s5_coord_in;
      end
   end

   assign rsp_valid           = s5_vld_ff;
   assign rsp_status          = s5_head_ff.status;
   assign rsp_sat_count       = s5_head_ff.sat_count;
   assign rsp_latitude_micro  = s5_coord_ff[0];
   assign rsp_longitude_micro = s5_coord_ff[1];
   assign rsp_time_valid      = s5_head_ff.time_valid;
   assign rsp_hour            = s5_head_ff.hour;
   assign rsp_minute          = s5_head_ff.minute;
   assign rsp_second          = s5_head_ff.second;

   `NGFE_ASSERT_IMPLY(a_clear_payload, clock, reset, rsp_valid && rsp_status != STATUS_FIX, rsp_latitude_micro == '0 && rsp_longitude_micro == '0 && rsp_sat_count == '0 && !rsp_time_valid, "payload not cleared for a non fix status")
   `NGFE_ASSERT_IMPLY(a_fix_sats, clock, reset, rsp_valid && rsp_status == STATUS_FIX, rsp_sat_count != '0 && rsp_sat_count <= SAT_MAX, "fix report with a bad satellite count")
   `NGFE_ASSERT_ALWAYS(a_bpos_cap, clock, reset, bpos_ff <= BPOS_W'(MAX_BYTES) && field_ff <= FIELD_W'(MAX_FIELDS - 1), "byte or field count beyond its cap")
   `NGFE_ASSERT_IMPLY(a_term_block, clock, reset, byte_vld_ff && is_term && s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff && s5_vld_ff && rsp_stall, req_stall, "terminator taken into a full pipeline")

endmodule
